### src/ffa_pkg.sv
// Shared constants for the first-fit block allocator.
package ffa_pkg;

	localparam int HEADER_BYTES_DEF = 16;
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam logic [15:0] ARENA_RESET = 16'd4096;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

endpackage

### src/ffa_ram.sv
// Generic simple dual-port RAM with registered read.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/first_fit_block_allocator.sv
// Top level: first-fit block allocator with merge of free neighbors.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------
//  request  | action, request_size, block_address           | start & !busy
//  result   | payload_address, status                       | result_valid strobe
//  config   | arena_size                                    | arena_size_we
//
// Allocate: each block walked in the chain is read (S_ARD) and evaluated (S_AEV);
// a split adds a write of the shortened block (S_AWR2). Free: each block searched
// is read (S_FRD) and evaluated (S_FEV), slot 0 is fetched (S_MR0, S_MRN), then the
// merge pass takes one link per cycle; all reads share the one read port of the table.
// After reset or an arena_size write, an init state rebuilds slot 0 (busy high).
// The result shows for one cycle; the receiver cannot stall it.
module first_fit_block_allocator #(
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] request_size,
	input  logic [15:0] block_address,
	input  logic        arena_size_we,
	input  logic [15:0] arena_size,
	output logic        result_valid,
	output logic [15:0] payload_address,
	output logic [1:0]  status
);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam logic [15:0] HB = 16'(HEADER_BYTES);

	typedef struct packed {
		logic [15:0]   start;
		logic [15:0]   len;
		logic          free;
		logic          hn;
		logic [IW-1:0] nxt;
	} slot_t;

	localparam int SW = $bits(slot_t);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_INIT = 10'b0000000010,
		S_ARD  = 10'b0000000100,
		S_AEV  = 10'b0000001000,
		S_AWR2 = 10'b0000010000,
		S_FRD  = 10'b0000100000,
		S_FEV  = 10'b0001000000,
		S_MR0  = 10'b0010000000,
		S_MRN  = 10'b0100000000,
		S_MEV  = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic [15:0]        arena_q;
	logic [MAX_BLOCKS-1:0] spare_q;
	logic               empty_q;
	logic [IW-1:0]      cur_q;
	slot_t              blk_q;
	logic [15:0]        want_q;
	logic [15:0]        where_q;

	logic               we;
	logic [IW-1:0]      waddr;
	slot_t              wdata;
	logic [IW-1:0]      raddr;
	logic [SW-1:0]      rdata_raw;
	slot_t              rd;

	ffa_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign rd   = slot_t'(rdata_raw);
	assign busy = (state_q != S_IDLE);

	// lowest spare slot above zero
	logic          spare_any;
	logic [IW-1:0] spare_idx;
	always_comb begin
		spare_any = 1'b0;
		spare_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 1; i--) begin
			if (spare_q[i]) begin
				spare_any = 1'b1;
				spare_idx = IW'(i);
			end
		end
	end

	// evaluation terms of the slot just read
	logic        fits;
	logic [15:0] rest;
	logic        split;
	logic [16:0] pay_rd;
	always_comb begin
		fits   = rd.free && (rd.len >= want_q);
		rest   = rd.len - want_q;
		split  = (rest > HB) && spare_any;
		pay_rd = {1'b0, rd.start} + {1'b0, HB};
	end

	// read address; the merge pass always fetches the successor of the slot in hand
	always_comb begin
		unique case (state_q) inside
			S_MR0:        raddr = '0;
			S_MRN, S_MEV: raddr = rd.nxt;
			default:      raddr = cur_q;
		endcase
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = rd;
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{start: 16'd0, len: arena_q - HB, free: 1'b1, hn: 1'b0,
					nxt: '0};
			end
			S_AEV: begin
				if (fits) begin
					we = 1'b1;
					if (split) begin
						waddr = spare_idx;
						wdata = '{start: rd.start + HB + want_q, len: rest - HB,
							free: 1'b1, hn: rd.hn, nxt: rd.nxt};
					end else begin
						wdata      = rd;
						wdata.free = 1'b0;
					end
				end
			end
			S_AWR2: begin
				we    = 1'b1;
				wdata = blk_q;
			end
			S_FEV: begin
				if (pay_rd == {1'b0, where_q}) begin
					we         = 1'b1;
					wdata      = rd;
					wdata.free = 1'b1;
				end
			end
			S_MEV: begin
				if (blk_q.free && rd.free) begin
					we    = 1'b1;
					wdata = '{start: blk_q.start, len: blk_q.len + rd.len + HB,
						free: 1'b1, hn: rd.hn, nxt: rd.nxt};
				end
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_INIT;
			arena_q         <= ffa_pkg::ARENA_RESET;
			spare_q         <= {{(MAX_BLOCKS-1){1'b1}}, 1'b0};
			empty_q         <= 1'b0;
			result_valid    <= 1'b0;
			payload_address <= '0;
			status          <= ffa_pkg::ST_DONE;
			cur_q           <= '0;
			blk_q           <= '0;
			want_q          <= '0;
			where_q         <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cur_q   <= '0;
						want_q  <= request_size;
						where_q <= block_address;
						payload_address <= '0;
						if (empty_q) begin
							result_valid <= 1'b1;
							status <= (action == ffa_pkg::ACT_FREE) ?
								ffa_pkg::ST_INVALID : ffa_pkg::ST_NOFIT;
						end else begin
							state_q <= (action == ffa_pkg::ACT_FREE) ? S_FRD : S_ARD;
						end
					end
				end
				S_INIT: begin
					spare_q <= {{(MAX_BLOCKS-1){1'b1}}, 1'b0};
					empty_q <= (arena_q < HB);
					state_q <= S_IDLE;
				end
				S_ARD: state_q <= S_AEV;
				S_AEV: begin
					if (fits) begin
						payload_address <= pay_rd[15:0];
						status          <= ffa_pkg::ST_DONE;
						if (split) begin
							spare_q[spare_idx] <= 1'b0;
							blk_q <= '{start: rd.start, len: want_q, free: 1'b0,
								hn: 1'b1, nxt: spare_idx};
							state_q <= S_AWR2;
						end else begin
							result_valid <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else if (!rd.hn) begin
						status       <= ffa_pkg::ST_NOFIT;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						cur_q   <= rd.nxt;
						state_q <= S_ARD;
					end
				end
				S_AWR2: begin
					result_valid <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_FRD: state_q <= S_FEV;
				S_FEV: begin
					if (pay_rd == {1'b0, where_q}) begin
						status  <= ffa_pkg::ST_DONE;
						state_q <= S_MR0;
					end else if (!rd.hn) begin
						status       <= ffa_pkg::ST_INVALID;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						cur_q   <= rd.nxt;
						state_q <= S_FRD;
					end
				end
				S_MR0: state_q <= S_MRN;
				S_MRN: begin
					// slot 0 has landed: hold it and fetch its successor
					cur_q <= '0;
					blk_q <= rd;
					if (!rd.hn) begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_MEV;
					end
				end
				S_MEV: begin
					// rd is the successor of blk_q: absorb it or step onto it
					if (blk_q.free && rd.free) begin
						spare_q[blk_q.nxt] <= 1'b1;
						blk_q <= '{start: blk_q.start, len: blk_q.len + rd.len + HB,
							free: 1'b1, hn: rd.hn, nxt: rd.nxt};
					end else begin
						cur_q <= blk_q.nxt;
						blk_q <= rd;
					end
					if (!rd.hn) begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_MEV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (arena_size_we) begin
				arena_q <= arena_size;
				state_q <= S_INIT;
			end
		end
	end

	// assertions
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ffa_pkg::ST_DONE || status == ffa_pkg::ST_NOFIT ||
			status == ffa_pkg::ST_INVALID))
		else $error("bad status code");
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ffa_pkg::ST_DONE) |-> payload_address == 16'd0)
		else $error("address on failed request");
	a_slot0_owned: assert property (@(posedge clk) disable iff (!arst_n)
		!spare_q[0])
		else $error("slot 0 marked spare");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !empty_q && !arena_size_we) |=> busy)
		else $error("accepted request did not go busy");
	a_init_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> (we && waddr == '0))
		else $error("init did not write slot 0");
endmodule
